### src/quoted_csv_field_splitter_defines.svh
// ----------------------------------------------------------------------------
// Quoted CSV field splitter assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_CSV_FIELD_SPLITTER_DEFINES_SVH
`define QUOTED_CSV_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication check.
`define QCSV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qcsv: same-cycle check failed");

// Next-cycle implication check.
`define QCSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qcsv: next-cycle check failed");

`endif

### src/qcsv_pkg.sv
// ----------------------------------------------------------------------------
// Quoted CSV field splitter package
// Character codes, parser mode codes and error codes.
// ----------------------------------------------------------------------------
package qcsv_pkg;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;

  // Parser modes.
  localparam logic [1:0] ModeOpen  = 2'd0;
  localparam logic [1:0] ModeField = 2'd1;
  localparam logic [1:0] ModeQuote = 2'd2;
  localparam logic [1:0] ModeSkip  = 2'd3;

  // Error codes reported with each result item.
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrQuote = 2'd1;
  localparam logic [1:0] ErrComma = 2'd2;
  localparam logic [1:0] ErrEnd   = 2'd3;

endpackage

### src/quoted_csv_field_splitter.sv
// ----------------------------------------------------------------------------
// Quoted CSV field splitter
// Timing: an accepted input item is registered in the input stage, and its parser result is
// registered in the result stage once that is free; a stalled result side holds it in between.
// Throughput: one item per cycle; only a stalled result side holds the input back.
// Reset: asynchronous active low; mode returns to expect-quote, count to zero.
// ----------------------------------------------------------------------------
`include "quoted_csv_field_splitter_defines.svh"

module quoted_csv_field_splitter
  import qcsv_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       last_in_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       char_valid_o,
  output logic [7:0] out_char_o,
  output logic       field_end_o,
  output logic       line_end_o,
  output logic [7:0] field_count_o,
  output logic [1:0] error_code_o
);

  // The count saturates at the smaller of MAX_FIELDS and the 8-bit maximum.
  localparam int unsigned LimitInt   = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
  localparam logic [7:0]  CountLimit = 8'(LimitInt);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       in_acc;

  logic       out_valid_q, out_valid_d;
  logic       char_valid_q;
  logic [7:0] out_char_q;
  logic       field_end_q;
  logic       line_end_q;
  logic [7:0] field_count_q;
  logic [1:0] error_code_q;

  logic [1:0] mode_q, mode_d;
  logic [7:0] fields_q, fields_d;

  logic       r_valid;
  logic [7:0] r_char;
  logic       r_fend;
  logic [1:0] r_err;
  logic [1:0] mode_nx;
  logic       bump;
  logic [7:0] fields_bumped;
  logic       is_quote;
  logic       is_comma;

  // Handshake: the input stage moves on whenever the result register is free.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Parser step for the item held in the input register.
  assign is_quote = (s1_char_q == CharQuote);
  assign is_comma = (s1_char_q == CharComma);

  always_comb begin
    r_valid = 1'b0;
    r_char  = 8'h00;
    r_fend  = 1'b0;
    r_err   = ErrNone;
    mode_nx = mode_q;
    bump    = 1'b0;
    unique case (mode_q)
      ModeOpen: begin
        if (!is_quote) begin
          r_err   = ErrQuote;
          mode_nx = ModeSkip;
        end else if (s1_last_q) begin
          r_err   = ErrEnd;
          mode_nx = ModeSkip;
        end else begin
          mode_nx = ModeField;
        end
      end
      ModeField: begin
        if (is_quote) begin
          if (s1_last_q) begin
            r_fend  = 1'b1;
            bump    = 1'b1;
            mode_nx = ModeOpen;
          end else begin
            mode_nx = ModeQuote;
          end
        end else if (s1_last_q) begin
          r_err   = ErrEnd;
          mode_nx = ModeSkip;
        end else begin
          r_valid = 1'b1;
          r_char  = s1_char_q;
        end
      end
      ModeQuote: begin
        if (is_quote) begin
          if (s1_last_q) begin
            r_err   = ErrEnd;
            mode_nx = ModeSkip;
          end else begin
            r_valid = 1'b1;
            r_char  = CharQuote;
            mode_nx = ModeField;
          end
        end else if (is_comma) begin
          r_fend  = 1'b1;
          bump    = 1'b1;
          mode_nx = ModeOpen;
        end else begin
          r_err   = ErrComma;
          mode_nx = ModeSkip;
        end
      end
      ModeSkip: begin
        mode_nx = ModeSkip;
      end
      default: begin
        mode_nx = ModeSkip;
      end
    endcase
  end

  // Saturating field count and line-end return to the initial state.
  assign fields_bumped = (bump && (fields_q < CountLimit)) ? fields_q + 8'd1 : fields_q;

  always_comb begin
    mode_d   = mode_q;
    fields_d = fields_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        mode_d   = ModeOpen;
        fields_d = 8'd0;
      end else begin
        mode_d   = mode_nx;
        fields_d = fields_bumped;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeOpen;
      fields_q    <= 8'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      fields_q    <= fields_d;
    end
  end

  // Payload registers of the input and result stages.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= in_char_i;
      s1_last_q <= last_in_line_i;
    end
    if (s1_adv) begin
      char_valid_q  <= r_valid;
      out_char_q    <= r_char;
      field_end_q   <= r_fend;
      line_end_q    <= s1_last_q;
      field_count_q <= fields_bumped;
      error_code_q  <= r_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_valid_o  = char_valid_q;
  assign out_char_o    = out_char_q;
  assign field_end_o   = field_end_q;
  assign line_end_o    = line_end_q;
  assign field_count_o = field_count_q;
  assign error_code_o  = error_code_q;

  // An error result never carries content or a field end.
  `QCSV_ASSERT_IMPL(a_err_excl, out_valid_o && error_code_o != ErrNone, !char_valid_o && !field_end_o)
  // The reported count never passes the saturation limit.
  `QCSV_ASSERT_IMPL(a_count_lim, out_valid_o, field_count_o <= CountLimit)
  // A line's last item puts the parser back into its initial state.
  `QCSV_ASSERT_NEXT(a_line_reset, s1_adv && s1_last_q, (mode_q == ModeOpen) && (fields_q == 8'd0))

endmodule

### test/csv_split_checker.sv
// ----------------------------------------------------------------------------
// Quoted CSV field splitter result checker
// Watches both channels of the splitter. Every accepted input item runs
// through a cycle-free parser model; the result items it predicts wait in a
// queue, and each accepted result item is compared field by field with the
// oldest of them.
// ----------------------------------------------------------------------------
module csv_split_checker
  import qcsv_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       last_in_line_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       char_valid_i,
  input  logic [7:0] out_char_i,
  input  logic       field_end_i,
  input  logic       line_end_i,
  input  logic [7:0] field_count_i,
  input  logic [1:0] error_code_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // The field count saturates at the smaller of the parameter and 255.
  localparam logic [7:0] CountCap = (MAX_FIELDS < 255) ? 8'(MAX_FIELDS) : 8'd255;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       field_end;
    logic       line_end;
    logic [7:0] field_count;
    logic [1:0] error_code;
  } split_t;

  logic [1:0] mode_q  = ModeOpen;
  logic [7:0] count_q = '0;
  split_t     pending_splits[$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_splits.size();

  // Parse one character, advance the line state and return the result item.
  function automatic split_t parse_char(input logic [7:0] c, input logic last);
    split_t r;
    r          = '0;
    r.line_end = last;
    case (mode_q)
      ModeOpen: begin
        // A missing quote outranks the line end.
        if (c != CharQuote) begin
          r.error_code = ErrQuote;
          mode_q       = ModeSkip;
        end else if (last) begin
          r.error_code = ErrEnd;
          mode_q       = ModeSkip;
        end else begin
          mode_q = ModeField;
        end
      end
      ModeField: begin
        if (c == CharQuote) begin
          if (last) begin
            // The closing quote ends the line and completes the field.
            r.field_end = 1'b1;
            if (count_q < CountCap) count_q = count_q + 8'd1;
            mode_q = ModeOpen;
          end else begin
            mode_q = ModeQuote;
          end
        end else if (last) begin
          r.error_code = ErrEnd;
          mode_q       = ModeSkip;
        end else begin
          r.char_valid = 1'b1;
          r.out_char   = c;
        end
      end
      ModeQuote: begin
        if (c == CharQuote) begin
          // A doubled quote is one literal quote, unless the line ends on it.
          if (last) begin
            r.error_code = ErrEnd;
            mode_q       = ModeSkip;
          end else begin
            r.char_valid = 1'b1;
            r.out_char   = CharQuote;
            mode_q       = ModeField;
          end
        end else if (c == CharComma) begin
          r.field_end = 1'b1;
          if (count_q < CountCap) count_q = count_q + 8'd1;
          mode_q = ModeOpen;
        end else begin
          r.error_code = ErrComma;
          mode_q       = ModeSkip;
        end
      end
      default: begin
        // Rest of a broken line: nothing to report.
      end
    endcase
    r.field_count = count_q;
    if (last) begin
      mode_q  = ModeOpen;
      count_q = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Predict on every accepted input item, compare on every accepted result item.
  always @(posedge clk_i or negedge rst_ni) begin
    split_t want;
    if (!rst_ni) begin
      mode_q  = ModeOpen;
      count_q = '0;
      pending_splits.delete();
    end else begin
      if (in_valid_i === 1'b1 && in_ready_i === 1'b1) begin
        pending_splits.push_back(parse_char(in_char_i, last_in_line_i));
      end
      if (out_valid_i === 1'b1 && out_ready_i === 1'b1) begin
        if (pending_splits.size() == 0) begin
          mismatches++;
          $display("%0t: result item mismatch, expected none, got char %0h count %0d",
                   $time, out_char_i, field_count_i);
        end else begin
          want = pending_splits.pop_front();
          check_field("char_valid", 8'(want.char_valid), 8'(char_valid_i));
          check_field("out_char", want.out_char, out_char_i);
          check_field("field_end", 8'(want.field_end), 8'(field_end_i));
          check_field("line_end", 8'(want.line_end), 8'(line_end_i));
          check_field("field_count", want.field_count, field_count_i);
          check_field("error_code", 8'(want.error_code), 8'(error_code_i));
        end
      end
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Quoted CSV field splitter testbench
// Drives character items into the splitter: a few directed lines for the
// error and edge cases, one line long enough to saturate the field count,
// then random lines, mostly well formed with random content, some broken or
// pure noise. Both sides stall at random. The checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top
  import qcsv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FieldLimit = 255;
  localparam int RandomItems = 1850;
  // No stalls on either side during the final items.
  localparam int CalmTail = 150;
  localparam int DrainLimit = 2000;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_char_i = '0;
  logic       last_in_line_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       char_valid_o;
  logic [7:0] out_char_o;
  logic       field_end_o;
  logic       line_end_o;
  logic [7:0] field_count_o;
  logic [1:0] error_code_o;

  int         fail_count;
  int         pending;
  bit         jitter_on = 1'b1;
  int         items_sent = 0;
  logic [7:0] line_q[$];

  quoted_csv_field_splitter #(
    .MAX_FIELDS(FieldLimit)
  ) u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_char_i,
    .last_in_line_i,
    .out_valid_o,
    .out_ready_i,
    .char_valid_o,
    .out_char_o,
    .field_end_o,
    .line_end_o,
    .field_count_o,
    .error_code_o
  );

  csv_split_checker #(
    .MAX_FIELDS(FieldLimit)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i(in_ready_o),
    .in_char_i,
    .last_in_line_i,
    .out_valid_i(out_valid_o),
    .out_ready_i,
    .char_valid_i(char_valid_o),
    .out_char_i(out_char_o),
    .field_end_i(field_end_o),
    .line_end_i(line_end_o),
    .field_count_i(field_count_o),
    .error_code_i(error_code_o),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hand one character to the splitter, after an optional gap.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_char_i      <= c;
    last_in_line_i <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      send_char(line_q[i], i == line_q.size() - 1);
    end
  endtask

  // Hold the sender until every predicted result item has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Bytes for noise, weighted toward the two characters the parser cares about.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0, 1: return CharQuote;
      2: return CharComma;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One quoted field with random content and some escaped quotes.
  task automatic add_field(input int max_len);
    int         len;
    logic [7:0] b;
    len = $urandom_range(0, max_len);
    line_q.push_back(CharQuote);
    repeat (len) begin
      if ($urandom_range(0, 4) == 0) begin
        line_q.push_back(CharQuote);
        line_q.push_back(CharQuote);
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CharQuote);
        line_q.push_back(b);
      end
    end
    line_q.push_back(CharQuote);
  endtask

  // A well formed line, sometimes with a trailing comma.
  task automatic build_record(input int fields, input int max_len);
    line_q.delete();
    for (int f = 0; f < fields; f++) begin
      if (f != 0) line_q.push_back(CharComma);
      add_field(max_len);
    end
    if ($urandom_range(0, 3) == 0) line_q.push_back(CharComma);
  endtask

  // Result side: random stall bursts while jitter is on.
  initial begin : result_sink
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (jitter_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin : stimulus
    int  kind;
    int  cut;
    bit  paused;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty field closed by the last byte of the line.
    send_char(CharQuote, 1'b0);
    send_char(CharQuote, 1'b1);
    // Opening quote as the only byte of a line.
    send_char(CharQuote, 1'b1);
    // Missing opening quote that is also the line end.
    send_char(8'h00, 1'b1);
    // Content byte as the last byte.
    send_char(CharQuote, 1'b0);
    send_char(8'hFF, 1'b1);
    // Doubled quote that ends the line.
    send_char(CharQuote, 1'b0);
    send_char(CharQuote, 1'b0);
    send_char(CharQuote, 1'b1);
    // Escaped quote inside a field, then a trailing comma.
    send_char(CharQuote, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(CharQuote, 1'b0);
    send_char(CharQuote, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(CharQuote, 1'b0);
    send_char(CharComma, 1'b1);
    // Missing comma after a closed field; the rest of the line is skipped.
    send_char(CharQuote, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(CharQuote, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(8'h79, 1'b1);
    // Missing opening quote at the start of a line; a later quote is skipped.
    send_char(8'h71, 1'b0);
    send_char(CharQuote, 1'b1);
    drain_results();

    // A line with more fields than the count can hold.
    items_sent = 0;
    build_record(FieldLimit + 3, 0);
    send_line();

    while (items_sent < RandomItems) begin
      jitter_on = (items_sent < RandomItems - CalmTail) && ($urandom_range(0, 3) != 0);
      if (!paused && items_sent > RandomItems / 2) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        build_record($urandom_range(1, 6), $urandom_range(0, 5));
        // Now and then damage one byte or cut the line short.
        if ($urandom_range(0, 6) == 0) begin
          line_q[$urandom_range(0, line_q.size() - 1)] = noise_byte();
        end
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, line_q.size());
          while (line_q.size() > cut) void'(line_q.pop_back());
        end
      end else begin
        line_q.delete();
        repeat ($urandom_range(1, 8)) line_q.push_back(noise_byte());
      end
      send_line();
    end

    // Let the last result items come out, then report the verdict.
    jitter_on = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int k = 0; k < DrainLimit && pending != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
